// ===== design/cwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cwc_pkg
// types and constants shared by the white-space collapse block and its
// channel interfaces
// ----------------------------------------------------------------------------
package cwc_pkg;

  localparam int CP_W      = 21;
  localparam int MODE_W    = 3;
  localparam int CASE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [CP_W-1:0] CH_TAB   = CP_W'('h09);
  localparam logic [CP_W-1:0] CH_LF    = CP_W'('h0A);
  localparam logic [CP_W-1:0] CH_VT    = CP_W'('h0B);
  localparam logic [CP_W-1:0] CH_FF    = CP_W'('h0C);
  localparam logic [CP_W-1:0] CH_CR    = CP_W'('h0D);
  localparam logic [CP_W-1:0] CH_SPACE = CP_W'('h20);
  localparam logic [CP_W-1:0] CH_UP_A  = CP_W'('h41);
  localparam logic [CP_W-1:0] CH_UP_Z  = CP_W'('h5A);
  localparam logic [CP_W-1:0] CH_LO_A  = CP_W'('h61);
  localparam logic [CP_W-1:0] CH_LO_Z  = CP_W'('h7A);
  localparam logic [CP_W-1:0] CASE_OFS = CP_W'('h20);
  localparam logic [CP_W-1:0] CP_NONE  = '0;

  localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NOWRAP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRE_LINE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PRE      = 3'd3;

  localparam logic [CASE_W-1:0] CASE_NONE  = 2'd0;
  localparam logic [CASE_W-1:0] CASE_UPPER = 2'd1;
  localparam logic [CASE_W-1:0] CASE_LOWER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE = 2'd1;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_result;
    logic            mode_error;
  } result_t;

endpackage

// ===== design/cwc_if.sv =====
// ----------------------------------------------------------------------------
// cwc channel interfaces
// valid/ready channels for text characters, rendered characters and
// register writes
// ----------------------------------------------------------------------------
interface cwc_text_if;
  logic                      valid;
  logic                      ready;
  logic [cwc_pkg::CP_W-1:0]  code_point;
  logic                      first_of_run;
  logic                      last_of_run;
  logic                      box_active;

  modport source (output valid, code_point, first_of_run, last_of_run, box_active,
                  input ready);
  modport sink   (input valid, code_point, first_of_run, last_of_run, box_active,
                  output ready);
endinterface

interface cwc_rendered_if;
  logic                      valid;
  logic                      ready;
  logic [cwc_pkg::CP_W-1:0]  out_code_point;
  logic                      last_result;
  logic                      mode_error;

  modport source (output valid, out_code_point, last_result, mode_error, input ready);
  modport sink   (input valid, out_code_point, last_result, mode_error, output ready);
endinterface

interface cwc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cwc_pkg::CFG_IDX_W-1:0]  index;
  logic [cwc_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/css_whitespace_collapse.sv =====
// ----------------------------------------------------------------------------
// css_whitespace_collapse
// collapses white-space runs of a text run (except in pre mode) and applies ascii case transform
// ----------------------------------------------------------------------------
// path: input register, then the word buffer, from which rendered words are read
// throughput: one character per cycle while the word buffer has room for two words;
//   the buffer drains one word per cycle while rendered.ready is high, and a character can give two words
// reset: rst (synchronous) clears mode, case transform, run state and buffer
// ----------------------------------------------------------------------------
module css_whitespace_collapse (
  input  logic                  clk,
  input  logic                  rst,
  cwc_text_if.sink              text,
  cwc_rendered_if.source        rendered,
  cwc_cfg_if.sink               cfg
);
  import cwc_pkg::*;

  logic [MODE_W-1:0]   ws_mode;
  logic [CASE_W-1:0]   case_mode;

  logic                s1_valid;
  logic [CP_W-1:0]     s1_cp;
  logic                s1_first;
  logic                s1_last;
  logic                s1_active;

  logic                space_pending;
  logic                break_seen;
  logic                stripping_leading;
  logic                space_pending_next;
  logic                break_seen_next;
  logic                stripping_leading_next;

  result_t             fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  head;
  logic [FIFO_AW-1:0]  tail;
  logic [FIFO_CW-1:0]  count;

  logic                advance;
  logic                pop;
  logic [1:0]          n_push;
  result_t             r0;
  result_t             r1;

  logic                sp0, bs0, sl0, sp1, bs1;
  logic                is_ws, is_brk, collapse, main_en, pre_flush, end_flush;
  logic [CP_W-1:0]     flush0_cp, end_cp, main_cp;
  logic                main_err;

  function automatic logic [CP_W-1:0] apply_case(input logic [CP_W-1:0] c,
                                                 input logic [CASE_W-1:0] m);
    logic [CP_W-1:0] r;
    r = c;
    if (m == CASE_UPPER && c >= CH_LO_A && c <= CH_LO_Z) begin
      r = c - CASE_OFS;
    end else if (m == CASE_LOWER && c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ws_mode   <= MODE_NORMAL;
      case_mode <= CASE_NONE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MODE: ws_mode   <= cfg.data;
        CFG_CASE: case_mode <= cfg.data[CASE_W-1:0];
        default:  ;
      endcase
    end
  end

  // input register
  assign advance    = s1_valid && (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign text.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_cp     <= text.code_point;
      s1_first  <= text.first_of_run;
      s1_last   <= text.last_of_run;
      s1_active <= text.box_active;
    end
  end

  // character handling
  always_comb begin
    sp0 = s1_first ? 1'b0 : space_pending;
    bs0 = s1_first ? 1'b0 : break_seen;
    sl0 = s1_first ? !s1_active : stripping_leading;

    is_brk   = (s1_cp == CH_LF) || (s1_cp == CH_CR) || (s1_cp == CH_FF) ||
               (s1_cp == CH_VT);
    is_ws    = is_brk || (s1_cp == CH_SPACE) || (s1_cp == CH_TAB);
    collapse = ws_mode <= MODE_PRE_LINE;

    main_en   = !is_ws || (!sl0 && !collapse);
    pre_flush = sp0 && main_en;
    flush0_cp = (ws_mode == MODE_PRE_LINE && bs0) ? CH_LF : CH_SPACE;

    main_err = 1'b0;
    if (!is_ws) begin
      main_cp = apply_case(s1_cp, case_mode);
    end else if (ws_mode == MODE_PRE) begin
      main_cp = s1_cp;
    end else begin
      main_cp  = CP_NONE;
      main_err = 1'b1;
    end

    if (main_en) begin
      sp1 = 1'b0;
      bs1 = 1'b0;
    end else if (is_ws && !sl0 && collapse) begin
      sp1 = 1'b1;
      bs1 = bs0 || is_brk;
    end else begin
      sp1 = sp0;
      bs1 = bs0;
    end

    end_flush = s1_last && sp1;
    end_cp    = (ws_mode == MODE_PRE_LINE && bs1) ? CH_LF : CH_SPACE;

    n_push = 2'(pre_flush) + 2'(main_en) + 2'(end_flush);

    r1.code_point  = main_cp;
    r1.mode_error  = main_err;
    r1.last_result = 1'b1;
    if (pre_flush) begin
      r0.code_point  = flush0_cp;
      r0.mode_error  = 1'b0;
      r0.last_result = 1'b0;
    end else if (main_en) begin
      r0.code_point  = main_cp;
      r0.mode_error  = main_err;
      r0.last_result = 1'b1;
    end else begin
      r0.code_point  = end_cp;
      r0.mode_error  = 1'b0;
      r0.last_result = 1'b1;
    end

    if (s1_last) begin
      space_pending_next     = 1'b0;
      break_seen_next        = 1'b0;
      stripping_leading_next = 1'b0;
    end else begin
      space_pending_next     = sp1;
      break_seen_next        = bs1;
      stripping_leading_next = is_ws ? sl0 : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_pending     <= 1'b0;
      break_seen        <= 1'b0;
      stripping_leading <= 1'b0;
    end else if (advance) begin
      space_pending     <= space_pending_next;
      break_seen        <= break_seen_next;
      stripping_leading <= stripping_leading_next;
    end
  end

  // rendered word buffer
  assign pop = rendered.valid && rendered.ready;

  always_ff @(posedge clk) begin
    if (advance && n_push != 2'd0) begin
      fifo[tail] <= r0;
    end
    if (advance && n_push == 2'd2) begin
      fifo[tail + FIFO_AW'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + FIFO_AW'(1);
      end
      if (advance) begin
        tail <= tail + FIFO_AW'(n_push);
      end
      count <= count + (advance ? FIFO_CW'(n_push) : '0) - FIFO_CW'(pop);
    end
  end

  assign rendered.valid          = count != '0;
  assign rendered.out_code_point = fifo[head].code_point;
  assign rendered.last_result    = fifo[head].last_result;
  assign rendered.mode_error     = fifo[head].mode_error;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("word buffer overflow");

  a_room_on_advance: assert property (@(posedge clk) disable iff (rst)
    advance |-> (count + FIFO_CW'(n_push) - FIFO_CW'(pop)) <= FIFO_CW'(FIFO_DEPTH))
    else $error("character handled without buffer room");

  a_break_needs_space: assert property (@(posedge clk) disable iff (rst)
    break_seen |-> space_pending)
    else $error("break flag without pending space");

  a_strip_no_space: assert property (@(posedge clk) disable iff (rst)
    !(stripping_leading && space_pending))
    else $error("pending space while stripping leading white space");

  a_error_word_zero: assert property (@(posedge clk) disable iff (rst)
    (rendered.valid && rendered.mode_error) |-> rendered.out_code_point == CP_NONE)
    else $error("error word carries a character");

endmodule
